// File: rtl/core/sccl_pkg.sv
// Package for the serial command code lock: widths, command words,
// response codes and the hex segment table. No dependencies.

package sccl_pkg;

    localparam int CODE_DIGITS  = 4;
    localparam int FRAME_LENGTH = 5;
    localparam int CMD_LEN      = 5;
    localparam int DISP_LEN     = 8;
    localparam int CNT_W        = $clog2(FRAME_LENGTH);
    localparam int POS_W        = 2;
    localparam int CMP_LEN      = (FRAME_LENGTH < CMD_LEN) ? FRAME_LENGTH : CMD_LEN;

    typedef logic [7:0]       t_byte;
    typedef logic [3:0]       t_digit;
    typedef logic [2:0]       t_resp;
    typedef logic [CNT_W-1:0] t_count;
    typedef logic [POS_W-1:0] t_pos;

    localparam t_resp RESP_NONE        = 3'd0;
    localparam t_resp RESP_CORRECT     = 3'd1;
    localparam t_resp RESP_WRONG       = 3'd2;
    localparam t_resp RESP_SETUP_START = 3'd3;
    localparam t_resp RESP_SETUP_DONE  = 3'd4;

    localparam t_byte CR_BYTE   = 8'h0d;
    localparam t_byte ZERO_CHAR = 8'h30;

    localparam t_byte SEG_O = 8'h3f;
    localparam t_byte SEG_P = 8'h73;
    localparam t_byte SEG_E = 8'h79;
    localparam t_byte SEG_N = 8'h54;
    localparam t_byte SEG_R = 8'h50;

    localparam t_byte WORD_ENTER [CMD_LEN] = '{8'h45, 8'h4e, 8'h54, 8'h45, 8'h52};
    localparam t_byte WORD_SET   [CMD_LEN] = '{8'h53, 8'h45, 8'h54, 8'h0d, 8'h0d};

    function automatic t_byte seg_hex(input t_digit d);
        t_byte s;
        case (d)
            4'h0: s = 8'h3f;
            4'h1: s = 8'h06;
            4'h2: s = 8'h5b;
            4'h3: s = 8'h4f;
            4'h4: s = 8'h66;
            4'h5: s = 8'h6d;
            4'h6: s = 8'h7d;
            4'h7: s = 8'h07;
            4'h8: s = 8'h7f;
            4'h9: s = 8'h6f;
            4'ha: s = 8'h77;
            4'hb: s = 8'h7c;
            4'hc: s = 8'h39;
            4'hd: s = 8'h5e;
            4'he: s = 8'h79;
            4'hf: s = 8'h71;
            default: s = 8'h00;
        endcase
        return s;
    endfunction

endpackage

// File: rtl/core/sccl_if.sv
// Valid/ready channel interfaces of the serial command code lock.
// Depends on sccl_pkg for the payload types.

interface sccl_rx_if;
    logic             valid;
    logic             ready;
    sccl_pkg::t_byte  rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sccl_res_if;
    logic             valid;
    logic             ready;
    sccl_pkg::t_byte  seg0;
    sccl_pkg::t_byte  seg1;
    sccl_pkg::t_byte  seg2;
    sccl_pkg::t_byte  seg3;
    sccl_pkg::t_byte  seg4;
    sccl_pkg::t_byte  seg5;
    sccl_pkg::t_byte  seg6;
    sccl_pkg::t_byte  seg7;
    sccl_pkg::t_resp  response;

    modport source (output valid, output seg0, output seg1, output seg2, output seg3,
                    output seg4, output seg5, output seg6, output seg7,
                    output response, input ready);
    modport sink   (input valid, input seg0, input seg1, input seg2, input seg3,
                    input seg4, input seg5, input seg6, input seg7,
                    input response, output ready);
endinterface

// File: rtl/core/serial_command_code_lock.sv
// Top level of the serial command code lock: frame assembly, command decode
// and the display image. Depends on sccl_pkg and the interfaces in sccl_if.sv.

// The lock takes one received byte per cycle on i_rx and groups the bytes into
// five-byte frames. The fifth byte of a frame is decoded in the same cycle it is
// accepted, and one result transaction (eight segment bytes and a response code)
// appears on o_res in the following cycle; bytes that do not close a frame
// produce nothing. The result sits in a single output register, so bytes that
// do not close a frame are taken even while a result waits; only the closing
// byte of the next frame waits until the pending result has been taken.
module serial_command_code_lock (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sccl_rx_if.sink       i_rx,
    sccl_res_if.source    o_res
);
    import sccl_pkg::*;

    t_byte  r_shift [FRAME_LENGTH-1];
    t_count r_count, n_count;
    t_digit r_stored [CODE_DIGITS];
    t_digit n_stored [CODE_DIGITS];
    t_digit r_entered [CODE_DIGITS];
    t_digit n_entered [CODE_DIGITS];
    t_pos   r_pos, n_pos;
    logic   r_setup, n_setup;
    logic   r_clear_pending, n_clear_pending;
    t_byte  r_disp [DISP_LEN];
    t_byte  n_disp [DISP_LEN];
    t_resp  r_resp, n_resp;
    logic   r_out_valid, n_out_valid;

    t_byte  w_frame [FRAME_LENGTH];
    logic   w_last;
    logic   w_accept;
    logic   w_is_enter;
    logic   w_is_set;
    logic   w_match;
    t_byte  w_digit;
    logic [2:0] w_disp_idx;

    assign w_last      = (r_count == t_count'(FRAME_LENGTH - 1));
    assign i_rx.ready  = !w_last || !r_out_valid || o_res.ready;
    assign w_accept    = i_rx.valid && i_rx.ready;

    // The frame as seen at the closing byte: earlier bytes from the shift line.
    always_comb begin
        for (int i = 0; i < FRAME_LENGTH - 1; i++) begin
            w_frame[i] = r_shift[i];
        end
        w_frame[FRAME_LENGTH-1] = i_rx.rx_byte;
    end

    always_comb begin
        w_is_enter = (FRAME_LENGTH == CMD_LEN);
        w_is_set   = (FRAME_LENGTH == CMD_LEN);
        for (int i = 0; i < CMP_LEN; i++) begin
            if (w_frame[i] != WORD_ENTER[i]) w_is_enter = 1'b0;
            if (w_frame[i] != WORD_SET[i])   w_is_set   = 1'b0;
        end
        w_match = 1'b1;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            if (r_entered[i] != r_stored[i]) w_match = 1'b0;
        end
    end

    assign w_digit    = w_frame[0] - ZERO_CHAR;
    assign w_disp_idx = 3'd4 + {1'b0, r_pos};

    always_comb begin
        n_count         = r_count;
        n_stored        = r_stored;
        n_entered       = r_entered;
        n_pos           = r_pos;
        n_setup         = r_setup;
        n_clear_pending = r_clear_pending;
        n_disp          = r_disp;
        n_resp          = r_resp;
        n_out_valid     = r_out_valid && !o_res.ready;

        if (w_accept) begin
            if (!w_last) begin
                n_count = r_count + t_count'(1);
            end else begin
                n_count     = '0;
                n_out_valid = 1'b1;
                n_resp      = RESP_NONE;
                if (w_is_enter) begin
                    for (int i = 0; i < DISP_LEN; i++) n_disp[i] = '0;
                    if (r_setup) begin
                        n_setup = 1'b0;
                        n_resp  = RESP_SETUP_DONE;
                    end else begin
                        n_clear_pending = 1'b1;
                        n_pos           = '0;
                        if (w_match) begin
                            n_disp[0] = SEG_O;
                            n_disp[1] = SEG_P;
                            n_disp[2] = SEG_E;
                            n_disp[3] = SEG_N;
                            n_resp    = RESP_CORRECT;
                        end else begin
                            n_disp[0] = SEG_E;
                            n_disp[1] = SEG_R;
                            n_disp[2] = SEG_R;
                            n_resp    = RESP_WRONG;
                        end
                    end
                end else if (w_is_set) begin
                    for (int i = 0; i < DISP_LEN; i++) n_disp[i] = '0;
                    n_setup = 1'b1;
                    n_pos   = '0;
                    n_resp  = RESP_SETUP_START;
                end else if (w_frame[1] == CR_BYTE && w_digit[7:4] == 4'h0) begin
                    // A digit above fifteen leaves the code and display as is.
                    if (r_pos == '0 && r_clear_pending) begin
                        for (int i = 0; i < DISP_LEN; i++) n_disp[i] = '0;
                    end
                    if (r_setup) n_stored[r_pos]  = w_digit[3:0];
                    else         n_entered[r_pos] = w_digit[3:0];
                    n_disp[w_disp_idx] = seg_hex(w_digit[3:0]);
                    if (r_pos == t_pos'(CODE_DIGITS - 1)) n_pos = '0;
                    else                                  n_pos = r_pos + t_pos'(1);
                end
            end
        end
    end

    // Shift line for the bytes of a frame before its closing byte.
    always_ff @(posedge i_clk) begin
        if (w_accept && !w_last) begin
            for (int i = 0; i < FRAME_LENGTH - 2; i++) begin
                r_shift[i] <= r_shift[i+1];
            end
            r_shift[FRAME_LENGTH-2] <= i_rx.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count         <= '0;
            r_pos           <= '0;
            r_setup         <= 1'b0;
            r_clear_pending <= 1'b0;
            r_resp          <= RESP_NONE;
            r_out_valid     <= 1'b0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                r_stored[i]  <= t_digit'(i + 1);
                r_entered[i] <= '0;
            end
            for (int i = 0; i < DISP_LEN; i++) begin
                r_disp[i] <= '0;
            end
        end else begin
            r_count         <= n_count;
            r_pos           <= n_pos;
            r_setup         <= n_setup;
            r_clear_pending <= n_clear_pending;
            r_resp          <= n_resp;
            r_out_valid     <= n_out_valid;
            r_stored        <= n_stored;
            r_entered       <= n_entered;
            r_disp          <= n_disp;
        end
    end

    // The display only changes when a frame closes, which also loads the
    // result, so the image registers serve directly as the result payload.
    assign o_res.valid    = r_out_valid;
    assign o_res.seg0     = r_disp[0];
    assign o_res.seg1     = r_disp[1];
    assign o_res.seg2     = r_disp[2];
    assign o_res.seg3     = r_disp[3];
    assign o_res.seg4     = r_disp[4];
    assign o_res.seg5     = r_disp[5];
    assign o_res.seg6     = r_disp[6];
    assign o_res.seg7     = r_disp[7];
    assign o_res.response = r_resp;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= t_count'(FRAME_LENGTH - 1))
        else $error("frame byte count out of range");

    a_result_from_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(w_accept && w_last))
        else $error("result appeared without a closing byte");

    a_setup_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_resp == RESP_SETUP_START) |-> r_setup)
        else $error("setup started but setup flag is clear");

    a_setup_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_resp == RESP_SETUP_DONE) |-> !r_setup)
        else $error("setup finished but setup flag is set");

    a_check_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_resp == RESP_CORRECT || r_resp == RESP_WRONG))
            |-> (r_clear_pending && r_pos == '0))
        else $error("code check did not arm the display clear");

endmodule
